// ----- src/crast_pkg.sv -----
// Shared types and constants for the circle rasterizer.
// Used by the pixel channel interface, the front, queue and back modules, and the top level.
package crast_pkg;

  localparam int FRAME_W     = 11;
  localparam int COLOR_W     = 24;
  localparam int PIX_OUT_W   = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int QUEUE_DEPTH = 2;
  localparam int SLOT_W      = 3;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 11'd600;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;
  localparam logic [SLOT_W-1:0]  LAST_SLOT   = 3'd7;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_DRAW_COLOR   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
    logic [COLOR_W-1:0] draw_color;
  } frame_cfg_t;

  // queue entry: center x, center y, major offset, minor offset, last flag
  function automatic int entry_width(input int coord_bits);
    return 4 * coord_bits + 3;
  endfunction

endpackage

// ----- src/crast_if.sv -----
// Request and pixel channel interfaces for the circle rasterizer.
// Depends on crast_pkg for the fixed pixel field widths.
interface crast_in_if #(
  parameter int COORD_BITS = 10
) ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-1:0] edge_x;
  logic [COORD_BITS-1:0] edge_y;

  modport source (output valid, cmd, center_x, center_y, edge_x, edge_y, input ready);
  modport sink (input valid, cmd, center_x, center_y, edge_x, edge_y, output ready);
endinterface

interface crast_out_if import crast_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [PIX_OUT_W-1:0] pixel_x;
  logic signed [PIX_OUT_W-1:0] pixel_y;
  logic [COLOR_W-1:0]          pixel_color;
  logic                        in_frame;
  logic                        last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, in_frame, last_pixel,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, in_frame, last_pixel,
                output ready);
endinterface

// ----- src/crast_front.sv -----
// Front end: accepts start and step requests, runs the midpoint iteration and
// pushes one octant point per drawing request into the queue. Depends on crast_pkg.
module crast_front import crast_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  crast_in_if.sink                            in_ch,
  input  logic                                q_ready,
  output logic                                q_push,
  output logic [entry_width(COORD_BITS)-1:0]  q_data
);

  localparam int OFF_W = COORD_BITS + 1;
  localparam int ERR_W = COORD_BITS + 4;
  localparam logic signed [ERR_W-1:0] ERR_ONE = ERR_W'(1);

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [OFF_W-1:0]      major;
    logic [OFF_W-1:0]      minor;
    logic                  last;
  } entry_t;

  logic                    active_r, active_nxt;
  logic [COORD_BITS-1:0]   cx_r, cx_nxt, cy_r, cy_nxt;
  logic [OFF_W-1:0]        major_r, major_nxt, minor_r, minor_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;

  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic [COORD_BITS-1:0]      dx, dy, radius;
  logic signed [ERR_W-1:0]    minor2, major2, e1, e2;
  logic [ERR_W-1:0]           e1_mag, e2_mag;
  logic                       y_only, done;
  logic [OFF_W-1:0]           step_major, step_minor;
  entry_t                     entry;

  assign in_ch.ready = q_ready;
  assign q_data      = entry;

  always_comb begin
    diff_x = $signed({1'b0, in_ch.edge_x}) - $signed({1'b0, in_ch.center_x});
    diff_y = $signed({1'b0, in_ch.edge_y}) - $signed({1'b0, in_ch.center_y});
    dx     = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
    dy     = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
    radius = (dx < dy) ? dy : dx;

    minor2 = $signed(ERR_W'({minor_r, 1'b0}));
    major2 = $signed(ERR_W'({major_r, 1'b0}));
    e1     = err_r + minor2 + ERR_ONE;
    e2     = e1 - major2 + ERR_ONE;
    e1_mag = e1[ERR_W-1] ? ERR_W'(-e1) : ERR_W'(e1);
    e2_mag = e2[ERR_W-1] ? ERR_W'(-e2) : ERR_W'(e2);
    y_only = e1_mag < e2_mag;

    step_major = y_only ? major_r : major_r - OFF_W'(1);
    step_minor = minor_r + OFF_W'(1);
    done       = step_major < step_minor;

    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    err_nxt    = err_r;
    q_push     = 1'b0;
    entry.cx    = cx_r;
    entry.cy    = cy_r;
    entry.major = step_major;
    entry.minor = step_minor;
    entry.last  = done;

    if (in_ch.valid && q_ready) begin
      if (cmd_t'(in_ch.cmd) == CMD_START) begin
        active_nxt  = 1'b1;
        cx_nxt      = in_ch.center_x;
        cy_nxt      = in_ch.center_y;
        major_nxt   = OFF_W'(radius);
        minor_nxt   = '0;
        err_nxt     = '0;
        q_push      = 1'b1;
        entry.cx    = in_ch.center_x;
        entry.cy    = in_ch.center_y;
        entry.major = OFF_W'(radius);
        entry.minor = '0;
        entry.last  = 1'b0;
      end else if (active_r) begin
        active_nxt = !done;
        major_nxt  = step_major;
        minor_nxt  = step_minor;
        err_nxt    = y_only ? e1 : e2;
        q_push     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    major_r <= major_nxt;
    minor_r <= minor_nxt;
    err_r   <= err_nxt;
  end

endmodule

// ----- src/crast_queue.sv -----
// Short request queue between the front and back ends of the circle rasterizer.
// Depends on crast_pkg for the queue depth.
module crast_queue import crast_pkg::*; #(
  parameter int WIDTH = 43
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != FULL_CNT;
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/crast_back.sv -----
// Back end: expands each queued octant point into eight mirrored pixels, one per
// cycle unless stalled, into a registered pixel channel. Depends on crast_pkg.
module crast_back import crast_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  frame_cfg_t                          cfg,
  input  logic                                q_valid,
  input  logic [entry_width(COORD_BITS)-1:0]  q_data,
  output logic                                q_pop,
  crast_out_if.source                         out_ch
);

  localparam int OFF_W = COORD_BITS + 1;
  localparam int PIX_W = COORD_BITS + 2;
  localparam int CMP_W = (PIX_W > FRAME_W) ? PIX_W : FRAME_W;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [OFF_W-1:0]      major;
    logic [OFF_W-1:0]      minor;
    logic                  last;
  } entry_t;

  entry_t                      ent;
  logic [SLOT_W-1:0]           slot_r, slot_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [PIX_OUT_W-1:0] px_r, py_r;
  logic [COLOR_W-1:0]          color_r;
  logic                        frame_r, last_r;

  logic                        load;
  logic [OFF_W-1:0]            u, v;
  logic signed [PIX_W-1:0]     cx_s, cy_s, u_s, v_s, px, py;
  logic                        px_in, py_in;

  assign ent = q_data;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = px_r;
  assign out_ch.pixel_y     = py_r;
  assign out_ch.pixel_color = color_r;
  assign out_ch.in_frame    = frame_r;
  assign out_ch.last_pixel  = last_r;

  always_comb begin
    load  = q_valid && (!out_valid_r || out_ch.ready);
    q_pop = load && (slot_r == LAST_SLOT);

    u    = slot_r[2] ? ent.minor : ent.major;
    v    = slot_r[2] ? ent.major : ent.minor;
    cx_s = $signed(PIX_W'(ent.cx));
    cy_s = $signed(PIX_W'(ent.cy));
    u_s  = $signed(PIX_W'(u));
    v_s  = $signed(PIX_W'(v));
    px   = slot_r[0] ? cx_s - u_s : cx_s + u_s;
    py   = slot_r[1] ? cy_s - v_s : cy_s + v_s;

    px_in = !px[PIX_W-1] && (CMP_W'($unsigned(px)) < CMP_W'(cfg.frame_width));
    py_in = !py[PIX_W-1] && (CMP_W'($unsigned(py)) < CMP_W'(cfg.frame_height));

    slot_nxt      = load ? slot_r + SLOT_W'(1) : slot_r;
    out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r    <= PIX_OUT_W'(px);
      py_r    <= PIX_OUT_W'(py);
      color_r <= cfg.draw_color;
      frame_r <= px_in && py_in;
      last_r  <= ent.last && (slot_r == LAST_SLOT);
    end
  end

endmodule

// ----- src/circle_rasterizer_unit.sv -----
// Midpoint circle rasterizer: a start request sets center and radius, each step
// request advances one octant point; every drawing request yields eight pixels.
// A drawing request occupies the pixel emitter for its eight pixels, one pixel
// per cycle while the pixel channel is not stalled; a step request with no circle
// in progress yields nothing. The front end takes a request every cycle while
// the two-entry queue has room, and the first pixel of a request is registered
// in the queue and then in the pixel output register before it is presented.
// Depends on crast_pkg, crast_if, crast_front, crast_queue and crast_back.
module circle_rasterizer_unit import crast_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  crast_in_if.sink              in_ch,
  crast_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ENTRY_W = entry_width(COORD_BITS);

  frame_cfg_t         cfg_r, cfg_nxt;
  logic               q_push, q_ready, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_wdata[FRAME_W-1:0];
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_wdata[FRAME_W-1:0];
        REG_DRAW_COLOR:   cfg_nxt.draw_color   = cfg_wdata[COLOR_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= FRAME_RESET;
      cfg_r.frame_height <= FRAME_RESET;
      cfg_r.draw_color   <= COLOR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  crast_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  crast_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_rdata)
  );

  crast_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- src/crast_checker.sv -----
// Port-level checks for circle_rasterizer_unit, attached by the bind below.
// Depends on crast_pkg for pixel field widths.
module crast_checker import crast_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [PIX_OUT_W-1:0] pixel_x,
  input logic signed [PIX_OUT_W-1:0] pixel_y,
  input logic [COLOR_W-1:0]          pixel_color,
  input logic                        in_frame,
  input logic                        last_pixel
);

  logic [SLOT_W-1:0]           slot_r;
  logic signed [PIX_OUT_W-1:0] prev_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (out_valid && out_ready) begin
      slot_r <= slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready && !slot_r[0]) begin
      prev_y_r <= pixel_y;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({pixel_x, pixel_y, pixel_color, in_frame, last_pixel}))
    else $error("pixel request changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pixel request shown right after reset");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_pixel |-> slot_r == LAST_SLOT)
    else $error("last pixel flagged outside the eighth pixel of a group");

  a_pair_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && slot_r[0] |-> pixel_y == prev_y_r)
    else $error("mirrored pixel pair does not share its y coordinate");

endmodule

bind circle_rasterizer_unit crast_checker u_crast_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pixel_x     (out_ch.pixel_x),
  .pixel_y     (out_ch.pixel_y),
  .pixel_color (out_ch.pixel_color),
  .in_frame    (out_ch.in_frame),
  .last_pixel  (out_ch.last_pixel)
);
